### design/srd_pkg.sv
// shared types for the sprite run-length decoder
// no dependencies; imported by every module of the block but srd_in_reg
package srd_pkg;

    // decoder phase: header bytes or body bytes
    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    // header byte positions that trigger work
    localparam logic [2:0] HDR_POS_AREA = 3'd4;
    localparam logic [2:0] HDR_POS_LAST = 3'd7;

    // group codes and positions in the body
    localparam logic [7:0] GRP_TRANSPARENT = 8'h01;
    localparam logic [1:0] GRP_POS_COUNT   = 2'd1;
    localparam logic [1:0] GRP_POS_LAST    = 2'd3;

    // one pixel run
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] run_length;
        logic        sprite_last;
    } t_run;

    // up to two runs from one byte, already compacted to slot 0 first
    typedef struct packed {
        logic v0;
        t_run r0;
        logic v1;
        t_run r1;
    } t_slots;

    // result register status seen by the rest of the block
    typedef struct packed {
        logic a_valid;
        logic b_valid;
        logic free;
    } t_oq_status;

endpackage

### design/srd_in_reg.sv
// input register for the byte stream
// depends on: nothing outside this file
module srd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // room when empty or when the held byte leaves this cycle
    assign o_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_byte <= i_tdata;
        end
    end

endmodule

### design/srd_core.sv
// header parse, group decode and pixel accounting for one byte
// depends on: srd_pkg
module srd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output srd_pkg::t_slots o_slots
);
    import srd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hpos, n_hpos;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [23:0] r_grp, n_grp;
    logic [1:0]  r_gpos, n_gpos;
    logic [31:0] r_left, n_left;
    logic        r_skip, n_skip;

    logic [31:0] len_full;
    logic [31:0] bytes_dec;
    logic        hdr_done;
    logic        body_end;
    logic        run_v;
    t_run        run;
    logic [31:0] run_px;
    logic [31:0] left_after;
    t_run        pad;

    // shared decode of the current byte
    assign len_full  = {i_byte, r_bytes_left[23:0]};
    assign bytes_dec = r_bytes_left - 32'd1;
    assign hdr_done  = (r_phase == PH_HEADER) && (r_hpos == HDR_POS_LAST);
    assign body_end  = (r_phase == PH_BODY) && (bytes_dec == 32'd0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: if (hdr_done && len_full != 32'd0) n_phase = PH_BODY;
            PH_BODY:   if (body_end) n_phase = PH_HEADER;
            default:   n_phase = PH_HEADER;
        endcase
    end

    // group decode: run produced by this byte, if any
    always_comb begin
        run_v  = 1'b0;
        run    = '0;
        run_px = 32'd0;
        if (r_phase == PH_BODY && !r_skip) begin
            if (r_gpos == GRP_POS_COUNT && r_grp[7:0] == GRP_TRANSPARENT) begin
                run_v          = (i_byte != 8'd0);
                run.run_length = {24'd0, i_byte};
                run_px         = {24'd0, i_byte};
            end else if (r_gpos == GRP_POS_LAST) begin
                run_v          = ({i_byte, r_grp} != 32'd0);
                run.red        = r_grp[7:0];
                run.green      = r_grp[15:8];
                run.blue       = r_grp[23:16];
                run.alpha      = i_byte;
                run.run_length = 32'd1;
                // the all-zero end marker adds no pixel
                run_px         = {31'd0, run_v};
            end
        end
    end

    // remaining pixels to reach width*height, floored at zero
    assign left_after = (r_left > run_px) ? (r_left - run_px) : 32'd0;

    // closing padding run
    always_comb begin
        pad             = '0;
        pad.sprite_last = 1'b1;
        pad.run_length  = (r_phase == PH_HEADER) ? r_left : left_after;
    end

    // datapath next values
    always_comb begin
        n_hpos       = r_hpos;
        n_width      = r_width;
        n_height     = r_height;
        n_bytes_left = r_bytes_left;
        n_grp        = r_grp;
        n_gpos       = r_gpos;
        n_left       = r_left;
        n_skip       = r_skip;
        if (r_phase == PH_HEADER) begin
            unique case (r_hpos)
                3'd0: n_width[7:0]        = i_byte;
                3'd1: n_width[15:8]       = i_byte;
                3'd2: n_height[7:0]       = i_byte;
                3'd3: n_height[15:8]      = i_byte;
                3'd4: n_bytes_left[7:0]   = i_byte;
                3'd5: n_bytes_left[15:8]  = i_byte;
                3'd6: n_bytes_left[23:16] = i_byte;
                3'd7: n_bytes_left[31:24] = i_byte;
                default: n_hpos = r_hpos;
            endcase
            // sprite area once both dimensions are in
            if (r_hpos == HDR_POS_AREA) begin
                n_left = {16'd0, r_width} * {16'd0, r_height};
            end
            n_hpos = hdr_done ? 3'd0 : r_hpos + 3'd1;
            if (hdr_done) begin
                n_gpos = 2'd0;
                n_skip = 1'b0;
            end
        end else begin
            n_bytes_left = bytes_dec;
            n_left       = left_after;
            if (!r_skip) begin
                if ((r_gpos == GRP_POS_COUNT && r_grp[7:0] == GRP_TRANSPARENT)
                        || r_gpos == GRP_POS_LAST) begin
                    n_gpos = 2'd0;
                    if (r_gpos == GRP_POS_LAST && !run_v) n_skip = 1'b1;
                end else begin
                    case (r_gpos)
                        2'd0:    n_grp[7:0]   = i_byte;
                        2'd1:    n_grp[15:8]  = i_byte;
                        default: n_grp[23:16] = i_byte;
                    endcase
                    n_gpos = r_gpos + 2'd1;
                end
            end
            if (body_end) begin
                n_hpos = 3'd0;
                n_gpos = 2'd0;
                n_skip = 1'b0;
            end
        end
    end

    // result slots, compacted so slot 0 fills first
    always_comb begin
        o_slots    = '0;
        o_slots.r1 = pad;
        if (run_v) begin
            o_slots.v0 = 1'b1;
            o_slots.r0 = run;
            o_slots.v1 = body_end;
        end else begin
            o_slots.v0 = body_end || (hdr_done && len_full == 32'd0);
            o_slots.r0 = pad;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hpos  <= 3'd0;
            r_gpos  <= 2'd0;
            r_skip  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_gpos  <= n_gpos;
            r_skip  <= n_skip;
        end
    end

    // sizes and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 16'd0;
            r_height     <= 16'd0;
            r_bytes_left <= 32'd0;
            r_left       <= 32'd0;
        end else if (i_take) begin
            r_width      <= n_width;
            r_height     <= n_height;
            r_bytes_left <= n_bytes_left;
            r_left       <= n_left;
        end
    end

    // buffered group bytes
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_grp <= n_grp;
        end
    end

endmodule

### design/srd_out_reg.sv
// two-entry result register draining one run per request
// depends on: srd_pkg
module srd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  srd_pkg::t_slots     i_slots,
    output logic                o_tvalid,
    input  logic                i_tready,
    output srd_pkg::t_run       o_run,
    output srd_pkg::t_oq_status o_status
);
    import srd_pkg::*;

    logic r_a_valid;
    logic r_b_valid;
    t_run r_a;
    t_run r_b;
    logic pop;

    assign pop      = r_a_valid && i_tready;
    assign o_tvalid = r_a_valid;
    assign o_run    = r_a;

    // new pair may enter once the previous pair is gone or leaving
    always_comb begin
        o_status.a_valid = r_a_valid;
        o_status.b_valid = r_b_valid;
        o_status.free    = !r_a_valid || (!r_b_valid && pop);
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_load) begin
            r_a_valid <= i_slots.v0;
            r_b_valid <= i_slots.v1;
        end else if (pop) begin
            r_a_valid <= r_b_valid;
            r_b_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_slots.r0;
            r_b <= i_slots.r1;
        end else if (pop) begin
            r_a <= r_b;
        end
    end

endmodule

### design/sprite_rle_decoder_unit.sv
// top level of the sprite run-length decoder
// depends on: srd_pkg, srd_in_reg, srd_core, srd_out_reg
//
// channel  | dir | tdata                                      | tlast
// s_axis   | in  | [7:0] data_byte                            | -
// m_axis   | out | [7:0] red [15:8] green [23:16] blue        | sprite_last
//          |     | [31:24] alpha [63:32] run_length           |
//
// one byte per cycle sustained while m_axis takes each run: input register,
// one pass of decode logic, two-entry result register. a byte that closes a
// run and the body yields two runs; the next byte waits while the second drains.
// a run is held first as its byte in the input register, then in the result
// register, before it is valid on m_axis.
// synchronous active-low reset returns to the header phase.
// m_axis stalls back up through the result register to s_axis tready.
module sprite_rle_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [7:0]  i_tdata,    // [7:0] data_byte
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [63:0] o_tdata,    // red, green, blue, alpha, run_length
    output logic        o_tlast     // sprite_last
);
    import srd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    t_slots     slots;
    t_run       run;
    t_oq_status oq_status;

    // core consumes the held byte when the result register has room
    assign take = in_valid && oq_status.free;

    srd_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .i_take   (take),
        .o_valid  (in_valid),
        .o_byte   (in_byte)
    );

    srd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .o_slots (slots)
    );

    srd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_slots  (slots),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_run    (run),
        .o_status (oq_status)
    );

    // pack the run onto the master side
    assign o_tdata = {run.run_length, run.alpha, run.blue, run.green, run.red};
    assign o_tlast = run.sprite_last;

    // second result slot never holds a run without the first
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(oq_status.b_valid && !oq_status.a_valid))
        else $error("second result slot valid with first empty");

    // padding runs carry a transparent pixel
    a_pad_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tlast) |-> (o_tdata[31:0] == 32'd0))
        else $error("padding run with nonzero pixel");

    // decoded runs are never empty
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !o_tlast) |-> (o_tdata[63:32] != 32'd0))
        else $error("decoded run of zero length");

    // a consumed byte leaves no pending results behind the stall
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && oq_status.a_valid && !i_tready) |-> 1'b0)
        else $error("byte consumed while result register blocked");

endmodule

### verif/srd_run_checker.sv
`timescale 1ns / 100ps
// run checker for the sprite run-length decoder: watches both streams,
// predicts the pixel runs of every accepted byte and compares them in order
// depends on: srd_pkg
module srd_run_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,     // [7:0] data_byte
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [63:0] i_out_tdata,    // red, green, blue, alpha, run_length
    input  logic        i_out_tlast,    // sprite_last
    output int          o_err_count,
    output int          o_pending,
    output int          o_runs_checked,
    output int          o_sprites_closed
);
    import srd_pkg::*;

    // predicted decoder state
    t_phase      dec_phase;
    logic [2:0]  hdr_pos;
    logic [15:0] spr_width;
    logic [15:0] spr_height;
    logic [31:0] body_left;
    logic [23:0] grp_buf;
    logic [1:0]  grp_pos;
    logic [31:0] pix_done;
    logic [31:0] pix_total;
    logic        skipping;

    // runs predicted but not yet seen on the output stream
    t_run expected_runs[$];

    int err_total     = 0;
    int runs_checked  = 0;
    int sprites_done  = 0;

    task automatic flag_error(input string msg);
        $display("[%0t] run mismatch: %s", $realtime, msg);
        err_total++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s expected 0x%0h got 0x%0h (run %0d)",
                                 name, want, got, runs_checked));
    endtask

    task automatic queue_run(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a,
                             input logic [31:0] len, input logic last);
        t_run run;
        run.red         = r;
        run.green       = g;
        run.blue        = b;
        run.alpha       = a;
        run.run_length  = len;
        run.sprite_last = last;
        expected_runs.push_back(run);
    endtask

    // saturating pixel counter
    task automatic count_pixels(input logic [31:0] n);
        logic [32:0] sum;
        sum = {1'b0, pix_done} + {1'b0, n};
        pix_done = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endtask

    // padding run up to width*height, then back to the header
    task automatic close_sprite();
        logic [31:0] pad;
        pad = (pix_done < pix_total) ? pix_total - pix_done : 32'd0;
        queue_run(8'd0, 8'd0, 8'd0, 8'd0, pad, 1'b1);
        dec_phase = PH_HEADER;
        hdr_pos   = '0;
        grp_buf   = '0;
        grp_pos   = '0;
        skipping  = 1'b0;
        sprites_done++;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (dec_phase == PH_HEADER) begin
            // little-endian width, height, body length
            if (hdr_pos < 3'd2)
                spr_width[8*hdr_pos +: 8] = b;
            else if (hdr_pos < HDR_POS_AREA)
                spr_height[8*(hdr_pos - 3'd2) +: 8] = b;
            else
                body_left[8*(hdr_pos - HDR_POS_AREA) +: 8] = b;
            if (hdr_pos == HDR_POS_LAST) begin
                pix_total = {16'd0, spr_width} * {16'd0, spr_height};
                pix_done  = '0;
                grp_buf   = '0;
                grp_pos   = '0;
                skipping  = 1'b0;
                hdr_pos   = '0;
                dec_phase = PH_BODY;
                if (body_left == 32'd0)
                    close_sprite();
            end else begin
                hdr_pos = hdr_pos + 3'd1;
            end
        end else begin
            if (!skipping) begin
                if (grp_pos == GRP_POS_COUNT && grp_buf[7:0] == GRP_TRANSPARENT) begin
                    // transparent run, a zero count gives nothing
                    if (b != 8'd0) begin
                        queue_run(8'd0, 8'd0, 8'd0, 8'd0, {24'd0, b}, 1'b0);
                        count_pixels({24'd0, b});
                    end
                    grp_buf = '0;
                    grp_pos = '0;
                end else if (grp_pos == GRP_POS_LAST) begin
                    // literal pixel, all zero stops decoding
                    if (grp_buf == 24'd0 && b == 8'd0) begin
                        skipping = 1'b1;
                    end else begin
                        queue_run(grp_buf[7:0], grp_buf[15:8], grp_buf[23:16], b,
                                  32'd1, 1'b0);
                        count_pixels(32'd1);
                    end
                    grp_buf = '0;
                    grp_pos = '0;
                end else begin
                    grp_buf[8*grp_pos +: 8] = b;
                    grp_pos = grp_pos + 2'd1;
                end
            end
            body_left = body_left - 32'd1;
            if (body_left == 32'd0)
                close_sprite();
        end
    endtask

    task automatic check_run();
        t_run got;
        t_run want;
        got.red         = i_out_tdata[7:0];
        got.green       = i_out_tdata[15:8];
        got.blue        = i_out_tdata[23:16];
        got.alpha       = i_out_tdata[31:24];
        got.run_length  = i_out_tdata[63:32];
        got.sprite_last = i_out_tlast;
        if (expected_runs.size() == 0) begin
            flag_error($sformatf("run with none expected: len %0d last %0b",
                                 got.run_length, got.sprite_last));
        end else begin
            want = expected_runs.pop_front();
            compare_field("red",         32'(want.red),         32'(got.red));
            compare_field("green",       32'(want.green),       32'(got.green));
            compare_field("blue",        32'(want.blue),        32'(got.blue));
            compare_field("alpha",       32'(want.alpha),       32'(got.alpha));
            compare_field("run_length",  want.run_length,       got.run_length);
            compare_field("sprite_last", 32'(want.sprite_last), 32'(got.sprite_last));
        end
        runs_checked++;
    endtask

    // predict on accepted bytes, check accepted runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_phase  = PH_HEADER;
            hdr_pos    = '0;
            spr_width  = '0;
            spr_height = '0;
            body_left  = '0;
            grp_buf    = '0;
            grp_pos    = '0;
            pix_done   = '0;
            pix_total  = '0;
            skipping   = 1'b0;
            expected_runs.delete();
        end else begin
            if (i_in_tvalid && i_in_tready)
                decode_byte(i_in_tdata);
            if (i_out_tvalid && i_out_tready)
                check_run();
        end
        o_err_count      <= err_total;
        o_pending        <= expected_runs.size();
        o_runs_checked   <= runs_checked;
        o_sprites_closed <= sprites_done;
    end

endmodule

### verif/tb_sprite_rle_decoder_unit.sv
`timescale 1ns / 100ps
// testbench top for the sprite run-length decoder: builds sprite record
// streams, drives them with random gaps and stalls, and gives the verdict
// depends on: srd_pkg, sprite_rle_decoder_unit, srd_run_checker
module tb_sprite_rle_decoder_unit;
    import srd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int CALM_TAIL   = 300;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_tvalid = 1'b0;
    logic [7:0]  i_tdata  = 8'd0;
    logic        i_tready = 1'b0;
    logic        o_tready;
    logic        o_tvalid;
    logic [63:0] o_tdata;
    logic        o_tlast;

    int err_count;
    int pending;
    int runs_checked;
    int sprites_closed;

    // byte stream and the body of the record being built
    logic [7:0] byte_stream[$];
    logic [7:0] body_bytes[$];
    int         records_built = 0;

    // bit 0: sender idles, bit 1: receiver stalls
    logic [1:0] idle_mode = 2'b00;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sprite_rle_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata),
        .o_tlast  (o_tlast)
    );

    srd_run_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_tvalid      (i_tvalid),
        .i_in_tready      (o_tready),
        .i_in_tdata       (i_tdata),
        .i_out_tvalid     (o_tvalid),
        .i_out_tready     (i_tready),
        .i_out_tdata      (o_tdata),
        .i_out_tlast      (o_tlast),
        .o_err_count      (err_count),
        .o_pending        (pending),
        .o_runs_checked   (runs_checked),
        .o_sprites_closed (sprites_closed)
    );

    // record building
    task automatic add_raw(input logic [7:0] b);
        body_bytes.push_back(b);
    endtask

    task automatic add_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        body_bytes.push_back(r);
        body_bytes.push_back(g);
        body_bytes.push_back(b);
        body_bytes.push_back(a);
    endtask

    task automatic add_clear(input logic [7:0] count);
        body_bytes.push_back(GRP_TRANSPARENT);
        body_bytes.push_back(count);
    endtask

    task automatic emit_record(input logic [15:0] w, input logic [15:0] h,
                               input logic [31:0] len);
        byte_stream.push_back(w[7:0]);
        byte_stream.push_back(w[15:8]);
        byte_stream.push_back(h[7:0]);
        byte_stream.push_back(h[15:8]);
        byte_stream.push_back(len[7:0]);
        byte_stream.push_back(len[15:8]);
        byte_stream.push_back(len[23:16]);
        byte_stream.push_back(len[31:24]);
        foreach (body_bytes[k])
            byte_stream.push_back(body_bytes[k]);
        body_bytes.delete();
        records_built++;
    endtask

    // mostly small sprites, sometimes the full 16-bit range
    function automatic logic [15:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 16'($urandom_range(0, 12));
        else if (sel < 85)
            return 16'($urandom_range(0, 255));
        else if (sel < 95)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    // well-formed sprite with random groups
    task automatic put_sprite();
        int groups;
        int kind;
        logic [7:0] first;
        groups = $urandom_range(0, 12);
        for (int k = 0; k < groups; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                add_clear(($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
            end else if (kind < 95) begin
                do first = 8'($urandom); while (first == GRP_TRANSPARENT);
                if ($urandom_range(0, 9) == 0)
                    first = 8'd0;
                add_pixel(first, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                // end marker, the rest is skipped
                add_pixel(8'd0, 8'd0, 8'd0, 8'd0);
                repeat ($urandom_range(0, 6)) add_raw(8'($urandom));
                break;
            end
        end
        // partial group left at the end of the body
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) add_raw(8'($urandom));
        emit_record(pick_dim(), pick_dim(), 32'(body_bytes.size()));
    endtask

    // receiver side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_tready   <= 1'b0;
        end else if (idle_mode[1] && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_tready   <= 1'b0;
        end else begin
            i_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((i_tvalid && o_tready) || (o_tvalid && i_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d runs outstanding",
                     STALL_LIMIT, pending);
            $display("tb_sprite_rle_decoder_unit: errors");
            $finish;
        end
    end

    initial begin
        int idx;

        // empty body at the largest area: padding comes at once
        emit_record(16'hFFFF, 16'hFFFF, 32'd0);
        // max and zero transparent counts, zero-led literal, overfull, partial tail
        add_clear(8'hFF);
        add_clear(8'h00);
        add_pixel(8'hFF, 8'h00, 8'h80, 8'h01);
        add_pixel(8'h00, 8'h00, 8'h00, 8'h80);
        add_raw(8'h7F);
        add_raw(8'h10);
        add_raw(8'h20);
        emit_record(16'd2, 16'd3, 32'(body_bytes.size()));
        // all-zero pixel, rest of the body skipped
        add_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        add_raw(8'hAA);
        add_raw(8'hBB);
        add_raw(8'hCC);
        emit_record(16'd1, 16'd1, 32'(body_bytes.size()));

        // random records, mostly well formed, some pure noise
        while (byte_stream.size() < 1950) begin
            if ($urandom_range(0, 99) < 85) begin
                put_sprite();
            end else begin
                repeat ($urandom_range(0, 24)) add_raw(8'($urandom));
                emit_record(16'($urandom), 16'($urandom), 32'(body_bytes.size()));
            end
        end
        // a body that never ends within the run
        add_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        add_clear(8'h40);
        add_pixel(8'hFE, 8'h01, 8'h7F, 8'h80);
        emit_record(pick_dim(), pick_dim(), 32'hFFFF_FFFF);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender side: byte requests with random gap bursts
        for (idx = 0; idx < byte_stream.size(); idx++) begin
            if (idx >= byte_stream.size() - CALM_TAIL)
                idle_mode = 2'b00;
            else
                idle_mode = 2'((idx / 200) % 4);
            if (idle_mode[0] && $urandom_range(0, 4) == 0) begin
                i_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_tvalid <= 1'b1;
            i_tdata  <= byte_stream[idx];
            @(posedge i_clk);
            while (!o_tready) @(posedge i_clk);
        end
        i_tvalid <= 1'b0;

        // drain, then allow the pipeline latency to settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes in %0d sprite records", byte_stream.size(), records_built);
        $display("checked %0d runs, %0d sprites closed with padding", runs_checked,
                 sprites_closed);
        if (err_count == 0)
            $display("tb_sprite_rle_decoder_unit: clean");
        else
            $display("tb_sprite_rle_decoder_unit: errors");
        $finish;
    end

endmodule

### files.f
design/srd_pkg.sv
design/srd_in_reg.sv
design/srd_core.sv
design/srd_out_reg.sv
design/sprite_rle_decoder_unit.sv
verif/srd_run_checker.sv
verif/tb_sprite_rle_decoder_unit.sv
